// File: hw/rtl/tdmh_pkg.sv
// Shared constants and types for the timer deadline min-heap.
`default_nettype none
package tdmh_pkg;
  localparam int CAPACITY  = 32;
  localparam int ID_BITS   = 8;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);
  localparam int MAX_RESULTS = 32;
  localparam int FCNT_BITS = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FIRED    = 3'd1;
  localparam logic [2:0] ST_NOTHING  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [63:0]        deadline;
    logic [31:0]        period;
  } entry_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic                wen;
    logic [IDX_BITS-1:0] waddr;
    entry_t              wdata;
    logic [IDX_BITS-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// File: hw/rtl/tdmh_ram.sv
// Single write, single registered read port heap slot memory.
`default_nettype none
module tdmh_ram (
  input  wire logic               clk,
  input  wire tdmh_pkg::mem_req_t req,
  output      tdmh_pkg::entry_t   rdata
);
  import tdmh_pkg::*;
  entry_t mem [CAPACITY];
  always_ff @(posedge clk) begin
    if (req.wen) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/timer_deadline_min_heap.sv
// Top level: timer min-heap sequencer with shared slot memory and comparator.
// Timer queue kept as a binary min-heap of up to 32 timers in one slot memory
// with one registered read port and one write port; one 64-bit less-than unit
// does every deadline compare. An item is accepted only while the block is idle.
// Zero deadline, full heap and unknown kind go straight to the emit state. An
// add sifts up one level per parent read and compare. A remove scans one slot per
// cycle (up to 32 slots), fetches the last entry, then sifts it down
// (and up when it did not move). A tick checks the root, fires it, reloads it or
// replaces it with the last entry and sifts down, at most 32 timers per tick,
// then closes. A fired result is held until the next due timer is known, so last
// is exact; the block also waits whenever its output register is full and
// out_stall is high.
`default_nettype none
module timer_deadline_min_heap (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  timer_id,
  input  wire logic [63:0] deadline,
  input  wire logic [31:0] period,
  input  wire logic [63:0] now,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  status,
  output      logic [7:0]  fired_id,
  output      logic [63:0] fired_deadline,
  output      logic        last
);
  import tdmh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_EMIT = 4'd1, S_UP_RD = 4'd2, S_UP_CMP = 4'd3,
    S_SC_RD = 4'd4, S_SC_CHK = 4'd5, S_RM_RD = 4'd6, S_RM_W = 4'd7, S_DN_ST = 4'd8,
    S_DN_L = 4'd9, S_DN_R = 4'd10, S_DN_MV = 4'd11, S_TK_RD = 4'd12, S_TK_CHK = 4'd13,
    S_TK_RL = 4'd14, S_TK_LD = 4'd15;

  logic [3:0] state, dn_next;
  logic [CNT_BITS-1:0] count;
  logic [IDX_BITS-1:0] pos, pick, par;
  logic [CNT_BITS:0] lch, rch, cnt_w;
  entry_t cur, oth, lent;
  logic [63:0] now_r;
  logic [ID_BITS-1:0] id_r;
  logic [FCNT_BITS-1:0] nfired;
  logic rm_up;   // run sift up after sift down (remove)
  logic moved;
  logic tick_op;
  logic pend_v;
  logic [2:0] res_status;
  logic [ID_BITS-1:0] res_id;
  logic [63:0] res_dl;
  logic [63:0] cmp_a, cmp_b;
  logic lt, fire, can_post, post;
  logic [64:0] sum;
  logic [63:0] reload_dl;
  mem_req_t req;
  entry_t rdata;

  tdmh_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign in_stall = (state != S_IDLE);
  assign par = (pos - IDX_BITS'(1)) >> 1;
  assign lch = (CNT_BITS+1)'({pos, 1'b1});
  assign rch = lch + 1'b1;
  assign cnt_w = (CNT_BITS+1)'(count);
  assign sum = {1'b0, now_r} + {33'd0, cur.period};
  assign reload_dl = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];

  // Shared deadline comparator.
  always_comb begin
    case (state)
      S_UP_CMP: begin cmp_a = cur.deadline; cmp_b = rdata.deadline; end
      S_DN_R:   begin cmp_a = lent.deadline; cmp_b = rdata.deadline; end
      S_DN_MV:  begin cmp_a = oth.deadline; cmp_b = cur.deadline; end
      S_TK_CHK: begin cmp_a = now_r; cmp_b = rdata.deadline; end
      default:  begin cmp_a = '0; cmp_b = '0; end
    endcase
  end
  assign lt = cmp_a < cmp_b;

  assign fire = (count != '0) && !lt && (nfired != FCNT_BITS'(MAX_RESULTS));
  assign can_post = !out_valid || !out_stall;
  assign post = (state == S_EMIT && can_post) ||
                (state == S_TK_CHK && fire && pend_v && can_post);

  always_comb begin
    if (rm_up && !moved) dn_next = S_UP_RD;
    else if (tick_op) dn_next = S_TK_RD;
    else dn_next = S_EMIT;
  end

  always_comb begin
    req = '0;
    case (state)
      S_UP_RD: begin
        req.raddr = par;
        if (pos == '0) begin
          req.wen = 1'b1; req.waddr = pos; req.wdata = cur;
        end
      end
      S_UP_CMP: begin
        req.wen = 1'b1; req.waddr = pos; req.wdata = lt ? rdata : cur;
      end
      S_SC_RD: req.raddr = pos;
      S_SC_CHK: req.raddr = pos + 1'b1;  // prefetch the next slot
      S_RM_RD: req.raddr = count[IDX_BITS-1:0];
      S_DN_ST: begin
        req.raddr = lch[IDX_BITS-1:0];
        if (lch >= cnt_w) begin
          req.wen = 1'b1; req.waddr = pos; req.wdata = cur;
        end
      end
      S_DN_L: req.raddr = rch[IDX_BITS-1:0];
      S_DN_MV: begin
        req.wen = 1'b1; req.waddr = pos; req.wdata = lt ? oth : cur;
      end
      S_TK_RL: req.raddr = IDX_BITS'(count - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; out_valid <= 1'b0; nfired <= '0; pend_v <= 1'b0;
      rm_up <= 1'b0; moved <= 1'b0; tick_op <= 1'b0;
    end else begin
      if (post) begin
        out_valid <= 1'b1; status <= res_status; fired_id <= res_id;
        fired_deadline <= res_dl; last <= (state == S_EMIT);
      end else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          res_id <= '0; res_dl <= '0; pend_v <= 1'b0; nfired <= '0;
          rm_up <= 1'b0; moved <= 1'b0;
          tick_op <= (kind == KIND_TICK);
          case (kind)
            KIND_TICK: begin
              now_r <= now; res_status <= ST_NOTHING; state <= S_TK_RD;
            end
            KIND_ADD: begin
              if (deadline == 64'd0) begin res_status <= ST_ZERO; state <= S_EMIT; end
              else if (count == CNT_BITS'(CAPACITY)) begin
                res_status <= ST_FULL; state <= S_EMIT;
              end else begin
                res_status <= ST_DONE;
                cur <= '{id: timer_id[ID_BITS-1:0], deadline: deadline, period: period};
                pos <= IDX_BITS'(count); count <= count + 1'b1;
                state <= S_UP_RD;
              end
            end
            KIND_REMOVE: begin
              id_r <= timer_id[ID_BITS-1:0]; pos <= '0;
              if (count == '0) begin res_status <= ST_NOTFOUND; state <= S_EMIT; end
              else begin res_status <= ST_DONE; state <= S_SC_RD; end
            end
            default: begin res_status <= ST_DONE; state <= S_EMIT; end
          endcase
        end
        S_EMIT: if (can_post) begin
          pend_v <= 1'b0;
          state <= S_IDLE;
        end
        // sift up: hole at pos, cur waits to be placed
        S_UP_RD: if (pos == '0) state <= S_EMIT; else state <= S_UP_CMP;
        S_UP_CMP: begin
          if (lt) begin pos <= par; state <= S_UP_RD; end
          else state <= S_EMIT;
        end
        // remove: linear scan, one slot per cycle
        S_SC_RD: state <= S_SC_CHK;
        S_SC_CHK: begin
          if (rdata.id == id_r) begin
            count <= count - 1'b1; state <= S_RM_RD;
          end else if (CNT_BITS'(pos) + 1'b1 >= count) begin
            res_status <= ST_NOTFOUND; state <= S_EMIT;
          end else pos <= pos + 1'b1;
        end
        S_RM_RD: state <= S_RM_W;  // last entry arrives next
        S_RM_W: begin
          cur <= rdata;
          if (CNT_BITS'(pos) < count) begin
            rm_up <= 1'b1; moved <= 1'b0; state <= S_DN_ST;
          end else state <= S_EMIT;
        end
        // sift down: hole at pos, cur waits to be placed
        S_DN_ST: begin
          if (lch >= cnt_w) begin rm_up <= 1'b0; state <= dn_next; end
          else state <= S_DN_L;
        end
        S_DN_L: begin
          lent <= rdata;
          if (rch < cnt_w) state <= S_DN_R;
          else begin
            oth <= rdata; pick <= lch[IDX_BITS-1:0]; state <= S_DN_MV;
          end
        end
        S_DN_R: begin
          // take the right child on a tie
          if (lt) begin oth <= lent; pick <= lch[IDX_BITS-1:0]; end
          else begin oth <= rdata; pick <= rch[IDX_BITS-1:0]; end
          state <= S_DN_MV;
        end
        S_DN_MV: begin
          if (lt) begin pos <= pick; moved <= 1'b1; state <= S_DN_ST; end
          else begin rm_up <= 1'b0; state <= dn_next; end
        end
        // tick: examine the root
        S_TK_RD: state <= S_TK_CHK;
        S_TK_CHK: begin
          if (fire) begin
            // hold until the previous fired item can go out
            if (!pend_v || can_post) begin
              res_status <= ST_FIRED; res_id <= rdata.id; res_dl <= rdata.deadline;
              pend_v <= 1'b1; nfired <= nfired + 1'b1; cur <= rdata;
              state <= S_TK_RL;
            end
          end else state <= S_EMIT;
        end
        S_TK_RL: begin
          if (cur.period == 32'd0) begin
            count <= count - 1'b1;
            if (count > CNT_BITS'(1)) state <= S_TK_LD; else state <= S_TK_RD;
          end else begin
            cur.deadline <= reload_dl; pos <= '0; moved <= 1'b0; state <= S_DN_ST;
          end
        end
        S_TK_LD: begin
          cur <= rdata; pos <= '0; moved <= 1'b0; state <= S_DN_ST;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY));
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({status, fired_id, fired_deadline, last}));
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_ZERO);
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FIRED |-> fired_id == '0 && fired_deadline == '0);
  a_nfired_cap: assert property (@(posedge clk) disable iff (rst)
    nfired <= FCNT_BITS'(MAX_RESULTS));
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the timer deadline min-heap.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tdmh_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int N_RANDOM = 260;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  id;
    logic [63:0] dl;
    logic        last;
  } result_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [63:0] dl;
    logic [31:0] per;
    logic [63:0] now;
    logic        has_exp;
    logic [2:0]  exp_status;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] kind = '0;
  logic [7:0] timer_id = '0;
  logic [63:0] deadline = '0;
  logic [31:0] period = '0;
  logic [63:0] now = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [2:0] status;
  logic [7:0] fired_id;
  logic [63:0] fired_deadline;
  logic last;

  timer_deadline_min_heap u_dut (
    .clk, .rst, .in_valid, .in_stall, .kind, .timer_id, .deadline, .period, .now,
    .out_valid, .out_stall, .status, .fired_id, .fired_deadline, .last
  );

  always #1 clk = ~clk;

  // Heap mirror
  logic [7:0]  h_id [CAPACITY];
  logic [63:0] h_dl [CAPACITY];
  logic [31:0] h_per [CAPACITY];
  int          h_cnt;
  result_t     pending_results[$];
  int          errors = 0;
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet_mode = 0;   // no idling
  bit          hold_off = 0;     // receiver held off
  logic [63:0] sim_now = 64'd100;

  function automatic void swap_slots(int a, int b);
    logic [7:0] ti;
    logic [63:0] td;
    logic [31:0] tp;
    ti = h_id[a]; h_id[a] = h_id[b]; h_id[b] = ti;
    td = h_dl[a]; h_dl[a] = h_dl[b]; h_dl[b] = td;
    tp = h_per[a]; h_per[a] = h_per[b]; h_per[b] = tp;
  endfunction

  function automatic void sink(int pos);
    int l, r, pick;
    while (pos < h_cnt) begin
      l = 2 * pos + 1;
      r = l + 1;
      if (l >= h_cnt) return;
      if (r >= h_cnt) pick = l;
      else pick = (h_dl[l] < h_dl[r]) ? l : r;
      if (h_dl[pick] < h_dl[pos]) begin
        swap_slots(pick, pos);
        pos = pick;
      end else return;
    end
  endfunction

  function automatic void rise(int pos);
    int par;
    while (pos > 0 && pos < h_cnt) begin
      par = (pos - 1) >> 1;
      if (h_dl[pos] < h_dl[par]) begin
        swap_slots(pos, par);
        pos = par;
      end else return;
    end
  endfunction

  function automatic void push_result(logic [2:0] st, logic [7:0] id, logic [63:0] dl);
    result_t r;
    r.status = st; r.id = id; r.dl = dl; r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Apply one item to the mirror and queue the results it causes.
  function automatic void predict_timers(stim_t s);
    int n;
    bit found;
    logic [64:0] sum;
    n = 0;
    case (s.kind)
      KIND_TICK: begin
        while (h_cnt > 0 && n < MAX_RESULTS && h_dl[0] <= s.now) begin
          push_result(ST_FIRED, h_id[0], h_dl[0]);
          n++;
          if (h_per[0] == 0) begin
            h_cnt--;
            if (h_cnt > 0) begin
              h_id[0] = h_id[h_cnt]; h_dl[0] = h_dl[h_cnt]; h_per[0] = h_per[h_cnt];
            end
          end else begin
            sum = {1'b0, s.now} + h_per[0];
            h_dl[0] = sum[64] ? '1 : sum[63:0];
          end
          if (h_cnt > 0) sink(0);
        end
        if (n == 0) push_result(ST_NOTHING, '0, '0);
      end
      KIND_ADD: begin
        if (s.dl == 0) push_result(ST_ZERO, '0, '0);
        else if (h_cnt >= CAPACITY) push_result(ST_FULL, '0, '0);
        else begin
          h_id[h_cnt] = s.id; h_dl[h_cnt] = s.dl; h_per[h_cnt] = s.per;
          h_cnt++;
          rise(h_cnt - 1);
          push_result(ST_DONE, '0, '0);
        end
      end
      KIND_REMOVE: begin
        found = 0;
        for (int i = 0; i < h_cnt; i++) begin
          if (!found && h_id[i] == s.id) begin
            h_cnt--;
            h_id[i] = h_id[h_cnt]; h_dl[i] = h_dl[h_cnt]; h_per[i] = h_per[h_cnt];
            if (i < h_cnt) begin
              sink(i);
              rise(i);
            end
            found = 1;
          end
        end
        push_result(found ? ST_DONE : ST_NOTFOUND, '0, '0);
      end
      default: push_result(ST_DONE, '0, '0);
    endcase
    pending_results[$].last = 1'b1;
  endfunction

  // Output side: idling and checking
  always @(posedge clk) begin
    result_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result status=%0d", status);
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (e.status !== status || e.id !== fired_id || e.dl !== fired_deadline ||
            e.last !== last) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: exp st=%0d id=%0d dl=%0h last=%0b got st=%0d id=%0d dl=%0h last=%0b",
                     e.status, e.id, e.dl, e.last, status, fired_id, fired_deadline, last);
          mismatches++;
        end
      end
    end
    if (hold_off) out_stall <= 1'b1;
    else if (quiet_mode) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 35);
  end

  // Drive one item, apply it to the mirror and check the predicted status of a directed row against its typed-in value.
  task automatic drive_item(stim_t s);
    while (!quiet_mode && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= s.kind; timer_id <= s.id; deadline <= s.dl; period <= s.per; now <= s.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timers(s);
    if (s.has_exp && pending_results[$].status !== s.exp_status) begin
      errors++;
      if (mismatches < 10)
        $display("directed row: predictor st=%0d, table st=%0d",
                 pending_results[$].status, s.exp_status);
      mismatches++;
    end
  endtask

  function automatic stim_t mk(logic [1:0] k, logic [7:0] id, logic [63:0] dl,
                               logic [31:0] per, logic [63:0] tnow, bit he,
                               logic [2:0] es);
    stim_t s;
    s.kind = k; s.id = id; s.dl = dl; s.per = per; s.now = tnow;
    s.has_exp = he; s.exp_status = es;
    return s;
  endfunction

  function automatic stim_t rand_item();
    stim_t s;
    int r;
    r = $urandom_range(99);
    s = mk(KIND_ADD, 8'($urandom_range(15)), '0, '0, '0, 0, ST_DONE);
    if (r < 45) begin
      s.dl = sim_now + $urandom_range(200);
      if ($urandom_range(19) == 0) s.dl = {$urandom, $urandom};
      if ($urandom_range(29) == 0) s.dl = '0;
      s.per = ($urandom_range(2) == 0) ? 32'($urandom_range(100)) : '0;
      if ($urandom_range(19) == 0) s.per = $urandom;
      if ($urandom_range(9) == 0) s.id = 8'($urandom);
    end else if (r < 75) begin
      s.kind = KIND_TICK;
      sim_now = sim_now + $urandom_range(60);
      s.now = sim_now;
      if ($urandom_range(29) == 0) s.now = {$urandom, $urandom};
      s.id = 8'($urandom); s.dl = {$urandom, $urandom}; s.per = $urandom;
    end else if (r < 95) begin
      s.kind = KIND_REMOVE;
    end else begin
      s.kind = KIND_UNUSED;
      s.id = 8'($urandom); s.dl = {$urandom, $urandom}; s.per = $urandom;
      s.now = {$urandom, $urandom};
    end
    return s;
  endfunction

  stim_t directed[$];

  initial begin
    h_cnt = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    directed.push_back(mk(KIND_TICK, 8'h00, '0, '0, '0, 1, ST_NOTHING));
    directed.push_back(mk(KIND_REMOVE, 8'h05, '0, '0, '0, 1, ST_NOTFOUND));
    directed.push_back(mk(KIND_ADD, 8'hFF, '0, 32'h1, '0, 1, ST_ZERO));
    directed.push_back(mk(KIND_UNUSED, 8'hAA, '1, '1, '1, 1, ST_DONE));
    directed.push_back(mk(KIND_ADD, 8'hFF, '1, '1, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_ADD, 8'h00, 64'd10, 32'd0, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_ADD, 8'h01, 64'd10, 32'd5, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_ADD, 8'h01, 64'd20, 32'd0, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_ADD, 8'h02, 64'd1, 32'hFFFFFFFF, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_TICK, '0, '0, '0, 64'd0, 1, ST_NOTHING));
    directed.push_back(mk(KIND_TICK, '0, '0, '0, 64'd10, 0, ST_DONE));
    directed.push_back(mk(KIND_REMOVE, 8'h01, '0, '0, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_TICK, '0, '0, '0, 64'hFFFFFFFFFFFFFFF0, 0, ST_DONE));
    directed.push_back(mk(KIND_TICK, '0, '0, '0, '1, 0, ST_DONE));
    directed.push_back(mk(KIND_REMOVE, 8'hFF, '0, '0, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_REMOVE, 8'h02, '0, '0, '0, 1, ST_DONE));
    directed.push_back(mk(KIND_REMOVE, 8'h01, '0, '0, '0, 0, ST_DONE));
    foreach (directed[i]) drive_item(directed[i]);

    // Fill the heap past capacity with equal and periodic deadlines, then fire all.
    for (int i = 0; i < CAPACITY + 2; i++)
      drive_item(mk(KIND_ADD, 8'(i), 64'd50 + (i % 3), 32'(i % 2), '0,
                    i >= CAPACITY, ST_FULL));
    drive_item(mk(KIND_TICK, '0, '0, '0, 64'd60, 0, ST_DONE));
    drive_item(mk(KIND_TICK, '0, '0, '0, 64'd61, 0, ST_DONE));
    in_valid <= 1'b0;

    // Sender pauses until everything is back.
    while (pending_results.size() != 0) @(posedge clk);

    // Receiver holds off while the sender keeps offering.
    hold_off <= 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++) drive_item(rand_item());
      end
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) quiet_mode = 1;
      if (i == 160) quiet_mode = 0;
      drive_item(rand_item());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hw/rtl/tdmh_pkg.sv
hw/rtl/tdmh_ram.sv
hw/rtl/timer_deadline_min_heap.sv
sim/tb_top.sv
